// ===== design/page_frame_allocator_core_assert.svh =====
// Assertion macros for the page frame allocator.
// Depends on nothing; included by the port checker.
`ifndef PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PFA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pfa_pkg.sv =====
// Types and constants shared by the page frame allocator.
// No dependencies.
package pfa_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_XLAT    = 2'd2
  } pfa_action_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NOFRAME = 3'd1,
    STAT_TBLFULL = 3'd2,
    STAT_TOOMANY = 3'd3,
    STAT_BADPID  = 3'd4,
    STAT_BADPAGE = 3'd5
  } pfa_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_REL_RD,
    S_REL_WR,
    S_XLAT_RD,
    S_XLAT_DATA,
    S_FIN
  } pfa_state_e;

  localparam logic       CFG_FRAMES = 1'b0;
  localparam logic       CFG_PSIZE  = 1'b1;

  localparam logic [8:0]  FRAMES_RST = 9'd256;
  localparam logic [4:0]  PSIZE_RST  = 5'd12;
  localparam int          LFSR_W     = 16;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

endpackage

// ===== design/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/page_frame_allocator_core.sv =====
// Page frame allocator: free map and page table in RAMs, one item at a time.
// Steps: a failed check or zero-page item goes straight to the result; translate reads
// the table; release frees each page; allocate runs a bit-serial lfsr mod, then probes, per page.
// After the result loads the FSM returns to idle, where the next item can be accepted; a stalled result holds the FSM.
// Reset and every write of frames_in_use start a free-map clearing pass
// during which no item is accepted.
module page_frame_allocator_core #(
  parameter int NUM_FRAMES = 256,
  parameter int MAX_PROCS  = 16,
  parameter int MAX_PAGES  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // process_id[3:0], request_bytes[24:4], page_index[29:25]
  input  logic [1:0]  s_axis_tuser_i,  // action[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // status[2:0], assigned_id[6:3], frame_number[14:7],
                                       // pages_count[20:15]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int FAW = $clog2(NUM_FRAMES);
  localparam int NW  = $clog2(NUM_FRAMES + 1);
  localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CPW = $clog2(MAX_PAGES + 1);
  localparam int TD  = MAX_PROCS * MAX_PAGES;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
  localparam int NF_RST = (256 > NUM_FRAMES) ? NUM_FRAMES : 256;

  pfa_pkg::pfa_state_e  state_q, state_d;
  pfa_pkg::pfa_status_e rs_status_q, rs_status_d;
  logic [3:0]     rs_id_q, rs_id_d;
  logic [7:0]     rs_frame_q, rs_frame_d;
  logic [5:0]     rs_cnt_q, rs_cnt_d;

  logic [8:0]     frames_q;
  logic [4:0]     psize_q;
  logic [15:0]    lfsr_q, lfsr_d, lfsr_nx;
  logic [NW-1:0]  free_q, free_d;
  logic           pv_q [MAX_PROCS];
  logic           pv_d [MAX_PROCS];
  logic [CPW-1:0] pc_q [MAX_PROCS];
  logic [CPW-1:0] pc_d [MAX_PROCS];

  logic [PW-1:0]  pid_q, pid_d;
  logic [CPW-1:0] p_q, p_d, pages_q, pages_d;
  logic [15:0]    dvd_q, dvd_d;
  logic [NW-1:0]  rem_q, rem_d;
  logic [3:0]     dcnt_q, dcnt_d;
  logic [FAW-1:0] f_q, f_d;

  logic           sweep_act_q;
  logic [FAW-1:0] sweep_addr_q;

  logic           out_valid_q, out_load;
  logic [23:0]    out_data_q;

  logic           s_fire, m_fire, cfg_fire, cfg_frames_wr;
  logic [NW-1:0]  nf, nf_new;
  logic [3:0]     in_pid;
  logic [20:0]    in_bytes;
  logic [4:0]     in_page;
  logic [31:0]    pid_ext, page_ext, pages_ext, slot_ext, tbl_lin;
  logic [PW-1:0]  pid_idx, slot;
  logic           slot_found, pid_ok;
  logic [21:0]    pages;
  logic           map_we, map_wdata;
  logic [FAW-1:0] map_waddr;
  logic [0:0]     map_rdata;
  logic           tbl_we;
  logic [TAW-1:0] tbl_addr;
  logic [FAW-1:0] tbl_rdata;
  logic [NW:0]    rem_sh, rem_sub;
  logic [NW-1:0]  rem_nx, f_inc;
  logic [FAW-1:0] f_wrap;

  assign s_fire        = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire        = m_axis_tvalid_o & m_axis_tready_i;
  assign cfg_fire      = cfg_valid_i & cfg_ready_o;
  assign cfg_frames_wr = cfg_fire && (cfg_index_i == pfa_pkg::CFG_FRAMES);
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready_o = (state_q == pfa_pkg::S_IDLE) && !sweep_act_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign nf     = (32'(frames_q) > NUM_FRAMES) ? NW'(NUM_FRAMES) : NW'(frames_q);
  assign nf_new = (32'(cfg_data_i) > NUM_FRAMES) ? NW'(NUM_FRAMES) : NW'(cfg_data_i);

  assign in_pid   = s_axis_tdata_i[3:0];
  assign in_bytes = s_axis_tdata_i[24:4];
  assign in_page  = s_axis_tdata_i[29:25];
  assign pid_ext  = 32'(in_pid);
  assign pid_idx  = pid_ext[PW-1:0];
  assign page_ext = 32'(in_page);
  assign pid_ok   = (pid_ext < MAX_PROCS) && pv_q[pid_idx];

  // round up to whole pages; shifts of 21 or more clear the quotient
  assign pages = 22'(in_bytes >> psize_q)
               + 22'(|(in_bytes & ~(21'h1FFFFF << psize_q)));
  assign pages_ext = 32'(pages);

  always_comb begin
    slot       = '0;
    slot_found = 1'b0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (!pv_q[i]) begin
        slot       = PW'(i);
        slot_found = 1'b1;
      end
    end
  end
  assign slot_ext = 32'(slot);

  assign lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? pfa_pkg::LFSR_TAPS : 16'h0000);

  // one restoring-division step of lfsr mod nf
  assign rem_sh  = {rem_q, dvd_q[15]};
  assign rem_sub = rem_sh - {1'b0, nf};
  assign rem_nx  = (rem_sh >= {1'b0, nf}) ? rem_sub[NW-1:0] : rem_sh[NW-1:0];

  assign f_inc  = NW'(f_q) + NW'(1);
  assign f_wrap = (f_inc == nf) ? '0 : f_inc[FAW-1:0];

  assign tbl_lin  = 32'(pid_q) * 32'(MAX_PAGES) + 32'(p_q);
  assign tbl_addr = tbl_lin[TAW-1:0];

  always_comb begin
    state_d     = state_q;
    rs_status_d = rs_status_q;
    rs_id_d     = rs_id_q;
    rs_frame_d  = rs_frame_q;
    rs_cnt_d    = rs_cnt_q;
    lfsr_d      = lfsr_q;
    free_d      = free_q;
    pv_d        = pv_q;
    pc_d        = pc_q;
    pid_d       = pid_q;
    p_d         = p_q;
    pages_d     = pages_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    f_d         = f_q;
    map_we      = 1'b0;
    map_waddr   = f_q;
    map_wdata   = 1'b0;
    tbl_we      = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      pfa_pkg::S_IDLE: begin
        if (s_fire) begin
          rs_status_d = pfa_pkg::STAT_OK;
          rs_id_d     = '0;
          rs_frame_d  = '0;
          rs_cnt_d    = '0;
          pid_d       = pid_idx;
          state_d     = pfa_pkg::S_FIN;
          unique case (s_axis_tuser_i)
            pfa_pkg::ACT_ALLOC: begin
              if (pages_ext > MAX_PAGES) begin
                rs_status_d = pfa_pkg::STAT_TOOMANY;
              end else if (!slot_found) begin
                rs_status_d = pfa_pkg::STAT_TBLFULL;
              end else if (pages_ext > 32'(free_q) || (pages != '0 && nf == '0)) begin
                rs_status_d = pfa_pkg::STAT_NOFRAME;
              end else if (pages == '0) begin
                pv_d[slot] = 1'b1;
                pc_d[slot] = '0;
                rs_id_d    = 4'(slot_ext);
              end else begin
                pid_d   = slot;
                pages_d = pages_ext[CPW-1:0];
                p_d     = '0;
                lfsr_d  = lfsr_nx;
                dvd_d   = lfsr_nx;
                rem_d   = '0;
                dcnt_d  = '0;
                state_d = pfa_pkg::S_DIV;
              end
            end
            pfa_pkg::ACT_RELEASE: begin
              if (!pid_ok) begin
                rs_status_d = pfa_pkg::STAT_BADPID;
              end else begin
                rs_cnt_d = 6'(pc_q[pid_idx]);
                p_d      = '0;
                if (pc_q[pid_idx] == '0) begin
                  pv_d[pid_idx] = 1'b0;
                end else begin
                  state_d = pfa_pkg::S_REL_RD;
                end
              end
            end
            pfa_pkg::ACT_XLAT: begin
              if (!pid_ok) begin
                rs_status_d = pfa_pkg::STAT_BADPID;
              end else if (page_ext >= 32'(pc_q[pid_idx]) || page_ext >= MAX_PAGES) begin
                rs_status_d = pfa_pkg::STAT_BADPAGE;
              end else begin
                p_d     = page_ext[CPW-1:0];
                state_d = pfa_pkg::S_XLAT_RD;
              end
            end
            default: begin
              rs_status_d = pfa_pkg::STAT_BADPID;
            end
          endcase
        end
      end

      pfa_pkg::S_DIV: begin
        rem_d  = rem_nx;
        dvd_d  = {dvd_q[14:0], 1'b0};
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'(pfa_pkg::LFSR_W - 1)) begin
          f_d     = rem_nx[FAW-1:0];
          state_d = pfa_pkg::S_PROBE_RD;
        end
      end

      pfa_pkg::S_PROBE_RD: begin
        state_d = pfa_pkg::S_PROBE_CHK;
      end

      pfa_pkg::S_PROBE_CHK: begin
        if (map_rdata[0]) begin
          f_d     = f_wrap;
          state_d = pfa_pkg::S_PROBE_RD;
        end else begin
          map_we    = 1'b1;
          map_waddr = f_q;
          map_wdata = 1'b1;
          tbl_we    = 1'b1;
          free_d    = free_q - NW'(1);
          p_d       = p_q + CPW'(1);
          if (p_q + CPW'(1) == pages_q) begin
            pv_d[pid_q] = 1'b1;
            pc_d[pid_q] = pages_q;
            rs_id_d     = 4'(pid_q);
            rs_cnt_d    = 6'(pages_q);
            state_d     = pfa_pkg::S_FIN;
          end else begin
            lfsr_d  = lfsr_nx;
            dvd_d   = lfsr_nx;
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = pfa_pkg::S_DIV;
          end
        end
      end

      pfa_pkg::S_REL_RD: begin
        state_d = pfa_pkg::S_REL_WR;
      end

      pfa_pkg::S_REL_WR: begin
        map_we    = 1'b1;
        map_waddr = tbl_rdata;
        map_wdata = 1'b0;
        free_d    = free_q + NW'(1);
        p_d       = p_q + CPW'(1);
        if (p_q + CPW'(1) == pc_q[pid_q]) begin
          pv_d[pid_q] = 1'b0;
          pc_d[pid_q] = '0;
          state_d     = pfa_pkg::S_FIN;
        end else begin
          state_d = pfa_pkg::S_REL_RD;
        end
      end

      pfa_pkg::S_XLAT_RD: begin
        state_d = pfa_pkg::S_XLAT_DATA;
      end

      pfa_pkg::S_XLAT_DATA: begin
        rs_frame_d = 8'(tbl_rdata);
        state_d    = pfa_pkg::S_FIN;
      end

      pfa_pkg::S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = pfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pfa_pkg::S_IDLE;
      end
    endcase

    // clearing pass owns the free-map write port
    if (sweep_act_q) begin
      map_we    = 1'b1;
      map_waddr = sweep_addr_q;
      map_wdata = 1'b0;
    end

    if (cfg_frames_wr) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        pv_d[i] = 1'b0;
        pc_d[i] = '0;
      end
      free_d = nf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pfa_pkg::S_IDLE;
      frames_q     <= pfa_pkg::FRAMES_RST;
      psize_q      <= pfa_pkg::PSIZE_RST;
      lfsr_q       <= pfa_pkg::LFSR_SEED;
      free_q       <= NW'(NF_RST);
      sweep_act_q  <= 1'b1;
      sweep_addr_q <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        pv_q[i] <= 1'b0;
        pc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      lfsr_q  <= lfsr_d;
      free_q  <= free_d;
      pv_q    <= pv_d;
      pc_q    <= pc_d;
      if (cfg_fire) begin
        if (cfg_index_i == pfa_pkg::CFG_FRAMES) begin
          frames_q <= cfg_data_i;
        end else begin
          psize_q <= cfg_data_i[4:0];
        end
      end
      if (cfg_frames_wr) begin
        sweep_act_q  <= 1'b1;
        sweep_addr_q <= '0;
      end else if (sweep_act_q) begin
        sweep_addr_q <= sweep_addr_q + FAW'(1);
        if (32'(sweep_addr_q) == NUM_FRAMES - 1) begin
          sweep_act_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rs_status_q <= rs_status_d;
    rs_id_q     <= rs_id_d;
    rs_frame_q  <= rs_frame_d;
    rs_cnt_q    <= rs_cnt_d;
    pid_q       <= pid_d;
    p_q         <= p_d;
    pages_q     <= pages_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    dcnt_q      <= dcnt_d;
    f_q         <= f_d;
    if (out_load) begin
      out_data_q <= {3'b000, rs_cnt_q, rs_frame_q, rs_id_q, rs_status_q};
    end
  end

  // bit set = frame in use
  pfa_ram #(
    .WIDTH (1),
    .DEPTH (NUM_FRAMES)
  ) u_free_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (f_q),
    .rdata_o (map_rdata)
  );

  pfa_ram #(
    .WIDTH (FAW),
    .DEPTH (TD)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_addr),
    .wdata_i (f_q),
    .raddr_i (tbl_addr),
    .rdata_o (tbl_rdata)
  );

endmodule

// ===== design/pfa_checker.sv =====
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_core_assert.svh.
`include "page_frame_allocator_core_assert.svh"

module pfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        cfg_index_i
);

  `PFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o),
    "result item changed while stalled")
  `PFA_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni,
    s_axis_tvalid_i && s_axis_tready_o,
    !s_axis_tready_o,
    "item accepted while busy")
  `PFA_ASSERT_NEXT(a_clear_blocks, clk_i, rst_ni,
    cfg_valid_i && cfg_ready_o && cfg_index_i == pfa_pkg::CFG_FRAMES,
    !s_axis_tready_o,
    "item accepted during free-map clear")
  `PFA_ASSERT_IMPL(a_status_range, clk_i, rst_ni,
    m_axis_tvalid_o,
    m_axis_tdata_o[2:0] <= pfa_pkg::STAT_BADPAGE && m_axis_tdata_o[23:21] == 3'd0,
    "bad status code")
  `PFA_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tdata_o[2:0] != pfa_pkg::STAT_OK,
    m_axis_tdata_o[20:3] == 18'd0,
    "failed item carries data")

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (.*);

// ===== tb/tb_page_frame_allocator_core.sv =====
// Self-checking testbench for page_frame_allocator_core: directed table, then random
// allocate/release/translate traffic over several frame-count and page-size settings.
// Depends on pfa_pkg and the core; a built-in predictor checks every result the table does not give.
`timescale 1ns / 100ps

module tb_page_frame_allocator_core;

  localparam int NFR = 256;
  localparam int NPROC = 16;
  localparam int NPG = 32;
  localparam int IDLE_LIMIT = 100000;

  typedef struct packed {
    logic [1:0]  act;
    logic [3:0]  pid;
    logic [20:0] bytes;
    logic [4:0]  page;
  } req_t;

  typedef struct packed {
    pfa_pkg::pfa_status_e status;
    logic [3:0]  id;
    logic [7:0]  frame;
    logic [5:0]  pages;
  } rsp_t;

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = pfa_pkg::CFG_FRAMES;
  logic [8:0] cfg_data = '0;
  wire s_tready, m_tvalid, cfg_ready;
  wire [23:0] m_tdata;

  page_frame_allocator_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // allocator mirror
  logic [8:0]  frames_reg;
  logic [4:0]  psize_reg;
  bit          frame_free[NFR];
  int          free_cnt;
  logic [7:0]  ptab[NPROC][NPG];
  int          proc_pages[NPROC];
  bit          proc_live[NPROC];
  logic [15:0] lfsr;

  rsp_t expected_q[$];
  int errors = 0, accepted = 0, results = 0, idle_cycles = 0;
  int stat_seen[8];
  int burst_left = 0;

  function automatic int managed();
    return (frames_reg > NFR) ? NFR : int'(frames_reg);
  endfunction

  function automatic void clear_frames();
    for (int i = 0; i < NFR; i++) frame_free[i] = 1'b1;
    for (int i = 0; i < NPROC; i++) begin
      proc_live[i] = 1'b0;
      proc_pages[i] = 0;
    end
    free_cnt = managed();
  endfunction

  function automatic rsp_t predict_alloc_map(req_t r);
    rsp_t o;
    int nf, slot, f;
    longint unsigned npages;
    logic lsb;
    o = '{pfa_pkg::STAT_OK, 4'd0, 8'd0, 6'd0};
    nf = managed();
    slot = NPROC;
    case (r.act)
      pfa_pkg::ACT_ALLOC: begin
        npages = (longint'(r.bytes) + (64'd1 << psize_reg) - 1) >> psize_reg;
        for (int i = NPROC - 1; i >= 0; i--) if (!proc_live[i]) slot = i;
        if (npages > NPG) o.status = pfa_pkg::STAT_TOOMANY;
        else if (slot >= NPROC) o.status = pfa_pkg::STAT_TBLFULL;
        else if (npages > free_cnt || (npages > 0 && nf == 0))
          o.status = pfa_pkg::STAT_NOFRAME;
        else begin
          for (int p = 0; p < int'(npages); p++) begin
            lsb = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb) lfsr = lfsr ^ pfa_pkg::LFSR_TAPS;
            f = int'(lfsr) % nf;
            for (int n = 0; n < nf && !frame_free[f]; n++) f = (f + 1 == nf) ? 0 : f + 1;
            frame_free[f] = 1'b0;
            free_cnt--;
            ptab[slot][p] = f[7:0];
          end
          proc_live[slot] = 1'b1;
          proc_pages[slot] = int'(npages);
          o.id = slot[3:0];
          o.pages = npages[5:0];
        end
      end
      pfa_pkg::ACT_RELEASE, pfa_pkg::ACT_XLAT: begin
        if (!proc_live[r.pid]) o.status = pfa_pkg::STAT_BADPID;
        else if (r.act == pfa_pkg::ACT_RELEASE) begin
          for (int p = 0; p < proc_pages[r.pid]; p++) begin
            f = ptab[r.pid][p];
            if (!frame_free[f]) begin
              frame_free[f] = 1'b1;
              free_cnt++;
            end
          end
          o.pages = proc_pages[r.pid][5:0];
          proc_pages[r.pid] = 0;
          proc_live[r.pid] = 1'b0;
        end else if (r.page >= proc_pages[r.pid]) o.status = pfa_pkg::STAT_BADPAGE;
        else o.frame = ptab[r.pid][r.page];
      end
      default: o.status = pfa_pkg::STAT_BADPID;
    endcase
    return o;
  endfunction

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results);
  endtask

  // result checker
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{pfa_pkg::pfa_status_e'(m_tdata[2:0]), m_tdata[6:3], m_tdata[14:7],
              m_tdata[20:15]};
      results++;
      if (expected_q.size() == 0) report("unexpected result, status", got.status, -1);
      else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.id !== want.id) report("assigned_id", got.id, want.id);
        if (got.frame !== want.frame) report("frame_number", got.frame, want.frame);
        if (got.pages !== want.pages) report("pages_count", got.pages, want.pages);
      end
    end
  end

  // receiver stalls follow a mask that changes every so often
  logic [15:0] stall_mask = 16'hFFFF;
  int mask_age = 0;
  always @(posedge clk_i) begin
    if (mask_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_mask <= 16'hFFFF;
        1: stall_mask <= 16'h00FF;
        default: stall_mask <= 16'($urandom());
      endcase
      mask_age <= int'($urandom_range(50, 400));
    end else begin
      mask_age <= mask_age - 1;
      stall_mask <= {stall_mask[14:0], stall_mask[15]};
    end
    m_tready <= stall_mask[15];
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_q.size());
      $display("status: fail");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic send(input req_t r, input logic typed, input rsp_t want);
    rsp_t pred;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : int'($urandom_range(1, 10));
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, r.page, r.bytes, r.pid};
    s_tuser <= r.act;
    do @(posedge clk_i); while (!s_tready);
    pred = predict_alloc_map(r);
    expected_q.push_back(typed ? want : pred);
    stat_seen[pred.status]++;
    accepted++;
    burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pfa_pkg::CFG_FRAMES) begin
      frames_reg = val;
      clear_frames();
    end else psize_reg = val[4:0];
  endtask

  function automatic req_t random_req();
    req_t r;
    int live[$];
    longint unsigned lim;
    int sel;
    r = '{2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 21'($urandom()),
          5'($urandom_range(0, 31))};
    for (int i = 0; i < NPROC; i++) if (proc_live[i]) live.push_back(i);
    sel = int'($urandom_range(0, 99));
    if (sel < 45) begin
      r.act = pfa_pkg::ACT_ALLOC;
      lim = longint'(NPG) << psize_reg;
      if (lim > 21'h1FFFFF) lim = 21'h1FFFFF;
      if ($urandom_range(0, 9) != 0) r.bytes = 21'($urandom_range(0, int'(lim)));
    end else if (sel < 70) begin
      r.act = pfa_pkg::ACT_RELEASE;
      if (live.size() != 0 && $urandom_range(0, 6) != 0)
        r.pid = 4'(live[$urandom_range(0, live.size() - 1)]);
    end else if (sel < 96) begin
      r.act = pfa_pkg::ACT_XLAT;
      if (live.size() != 0 && $urandom_range(0, 6) != 0) begin
        r.pid = 4'(live[$urandom_range(0, live.size() - 1)]);
        if (proc_pages[r.pid] != 0) r.page = 5'($urandom_range(0, proc_pages[r.pid] - 1));
      end
    end else r.act = 2'd3;
    return r;
  endfunction

  localparam rsp_t NONE = '{pfa_pkg::STAT_OK, 4'd0, 8'd0, 6'd0};

  row_t dir_rows[25] = '{
    '{'{pfa_pkg::ACT_XLAT, 4'd0, 21'd0, 5'd0}, 1'b1, '{pfa_pkg::STAT_BADPID, 4'd0, 8'd0, 6'd0}},
    '{'{2'd3, 4'd15, 21'h1FFFFF, 5'd31}, 1'b1, '{pfa_pkg::STAT_BADPID, 4'd0, 8'd0, 6'd0}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd0, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd0, 8'd0, 6'd0}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd15, 21'h1FFFFF, 5'd31}, 1'b1,
      '{pfa_pkg::STAT_TOOMANY, 4'd0, 8'd0, 6'd0}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd131072, 5'd0}, 1'b1,
      '{pfa_pkg::STAT_OK, 4'd1, 8'd0, 6'd32}},
    '{'{pfa_pkg::ACT_XLAT, 4'd1, 21'd0, 5'd31}, 1'b0, NONE},
    '{'{pfa_pkg::ACT_XLAT, 4'd0, 21'd0, 5'd0}, 1'b1, '{pfa_pkg::STAT_BADPAGE, 4'd0, 8'd0, 6'd0}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd2, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd4096, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd3, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd4, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd5, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd6, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd7, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd8, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd9, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd10, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd11, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd12, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd13, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd14, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd15, 8'd0, 6'd1}},
    '{'{pfa_pkg::ACT_ALLOC, 4'd0, 21'd1, 5'd0}, 1'b1,
      '{pfa_pkg::STAT_TBLFULL, 4'd0, 8'd0, 6'd0}},
    '{'{pfa_pkg::ACT_RELEASE, 4'd1, 21'd0, 5'd0}, 1'b1, '{pfa_pkg::STAT_OK, 4'd0, 8'd0, 6'd32}},
    '{'{pfa_pkg::ACT_RELEASE, 4'd1, 21'd0, 5'd0}, 1'b1,
      '{pfa_pkg::STAT_BADPID, 4'd0, 8'd0, 6'd0}},
    '{'{pfa_pkg::ACT_XLAT, 4'd15, 21'd0, 5'd0}, 1'b0, NONE}
  };

  // frame count / page size per random phase; zero and oversized counts included
  int ph_frames[6] = '{256, 1, 0, 300, 64, 17};
  int ph_psize[6]  = '{16, 0, 4, 12, 9, 7};

  initial begin
    frames_reg = pfa_pkg::FRAMES_RST;
    psize_reg = pfa_pkg::PSIZE_RST;
    lfsr = pfa_pkg::LFSR_SEED;
    clear_frames();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    foreach (ph_frames[p]) begin
      write_reg(pfa_pkg::CFG_FRAMES, ph_frames[p][8:0]);
      write_reg(pfa_pkg::CFG_PSIZE, ph_psize[p][8:0]);
      for (int k = 0; k < 100; k++) begin
        if (p == 0 && k == 50) drain();  // hold off until every result is back
        send(random_req(), 1'b0, NONE);
      end
    end
    drain();
    repeat (100) @(posedge clk_i);

    $display("%0d items, %0d results over %0d settings; ok %0d, no-frame %0d, full %0d",
             accepted, results, 7, stat_seen[pfa_pkg::STAT_OK],
             stat_seen[pfa_pkg::STAT_NOFRAME], stat_seen[pfa_pkg::STAT_TBLFULL]);
    $display("too-many %0d, bad pid %0d, bad page %0d, mismatches %0d",
             stat_seen[pfa_pkg::STAT_TOOMANY], stat_seen[pfa_pkg::STAT_BADPID],
             stat_seen[pfa_pkg::STAT_BADPAGE], errors);
    if (errors == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== page_frame_allocator_core.f =====
+incdir+design
design/pfa_pkg.sv
design/pfa_ram.sv
design/page_frame_allocator_core.sv
design/pfa_checker.sv
tb/tb_page_frame_allocator_core.sv
